// File: sv/qpan_pkg.sv
// ----------------------------------------------------------------------------
// qpan_pkg
// Shared constants and the pan law table generator for the quad panner.
// ----------------------------------------------------------------------------
package qpan_pkg;

	localparam int LAW_TABLE_DEPTH = 256;
	localparam int SAMPLE_BITS     = 24;
	localparam int GAIN_BITS       = 16;
	localparam int POS_BITS        = 16;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_JOYSTICK_X      = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_JOYSTICK_Y      = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UPDATE_DIVISION = 2'd2;

	localparam logic [CFG_DATA_BITS-1:0] UPDATE_DIVISION_RST = 16'd48;

	localparam int CORDIC_STEPS = 30;
	localparam int PRESCALE     = 20;

	// atan(2^-k) in Q2.30
	function automatic longint atan_step(input int k);
		longint r;
		r = 0;
		unique case (k)
			0:  r = 64'h3243F6A8;
			1:  r = 64'h1DAC6705;
			2:  r = 64'h0FADBAFC;
			3:  r = 64'h07F56EA6;
			4:  r = 64'h03FEAB76;
			5:  r = 64'h01FFD55B;
			6:  r = 64'h00FFFAAA;
			7:  r = 64'h007FFF55;
			8:  r = 64'h003FFFEA;
			9:  r = 64'h001FFFFD;
			10: r = 64'h000FFFFF;
			11: r = 64'h0007FFFF;
			12: r = 64'h0003FFFF;
			13: r = 64'h0001FFFF;
			14: r = 64'h0000FFFF;
			15: r = 64'h00007FFF;
			16: r = 64'h00003FFF;
			17: r = 64'h00001FFF;
			18: r = 64'h00000FFF;
			19: r = 64'h000007FF;
			20: r = 64'h000003FF;
			21: r = 64'h000001FF;
			22: r = 64'h000000FF;
			23: r = 64'h0000007F;
			24: r = 64'h0000003F;
			25: r = 64'h0000001F;
			26: r = 64'h0000000F;
			27: r = 64'h00000008;
			28: r = 64'h00000004;
			29: r = 64'h00000002;
			default: r = 0;
		endcase
		return r;
	endfunction

	// min(1, atan(1.7 t)) at the center of bin i, Q0.16; evaluated at elaboration only
	function automatic logic [GAIN_BITS-1:0] law_entry(input int i, input int depth);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = (longint'(20) * longint'(depth)) <<< PRESCALE;
		y = (longint'(17) * (2 * longint'(i) + 1)) <<< PRESCALE;
		z = 0;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_step(k);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_step(k);
			end
		end
		z = (z + (longint'(1) <<< 13)) >>> 14;
		if (z < 0)
			z = 0;
		if (z > 65535)
			z = 65535;
		return GAIN_BITS'(z);
	endfunction

endpackage

// File: sv/qpan_law_rom.sv
// ----------------------------------------------------------------------------
// qpan_law_rom
// Dual read port pan law ROM with registered read data.
// ----------------------------------------------------------------------------
module qpan_law_rom #(
	parameter int DEPTH = qpan_pkg::LAW_TABLE_DEPTH,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic [IW-1:0]                  addr_a,
	input  logic [IW-1:0]                  addr_b,
	output logic [qpan_pkg::GAIN_BITS-1:0] rdata_a,
	output logic [qpan_pkg::GAIN_BITS-1:0] rdata_b
);

	logic [qpan_pkg::GAIN_BITS-1:0] law_w [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_law
		assign law_w[g] = qpan_pkg::law_entry(g, DEPTH);
	end

	always_ff @(posedge clk) begin
		rdata_a <= law_w[addr_a];
		rdata_b <= law_w[addr_b];
	end

endmodule

// File: sv/qpan_mul.sv
// ----------------------------------------------------------------------------
// qpan_mul
// Serial-parallel multiplier: signed multiplicand times unsigned Q0.16 gain,
// one gain bit per cycle, LSB first. Result is floor(product / 2^16).
// ----------------------------------------------------------------------------
module qpan_mul #(
	parameter int MW = qpan_pkg::SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [MW-1:0]           mcand,
	input  logic [qpan_pkg::GAIN_BITS-1:0] mult,
	output logic                           busy,
	output logic signed [MW:0]             prod
);

	localparam int CW = $clog2(qpan_pkg::GAIN_BITS + 1);

	logic [CW-1:0]                  count_q;
	logic signed [MW-1:0]           mcand_q;
	logic [qpan_pkg::GAIN_BITS-1:0] mult_q;
	logic signed [MW:0]             hi_q;
	logic signed [MW+1:0]           sum;

	assign busy = (count_q != '0);
	assign prod = hi_q;

	assign sum = {hi_q[MW], hi_q} + (mult_q[0] ? {{2{mcand_q[MW-1]}}, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CW'(qpan_pkg::GAIN_BITS);
		end else if (busy) begin
			count_q <= count_q - 1'b1;
		end
	end

	// shifted-out product bits are dropped: the kept upper part is the floor
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			mult_q  <= mult;
			hi_q    <= '0;
		end else if (busy) begin
			hi_q   <= sum[MW+1:1];
			mult_q <= mult_q >> 1;
		end
	end

endmodule

// File: sv/quad_pan_law_vca_top.sv
// ----------------------------------------------------------------------------
// quad_pan_law_vca_top
// Quadraphonic constant-power panner: one sample in, four speaker feeds out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries sample, cv_x, cv_y. Output
//   channel (out_valid/out_ready) carries front_left, front_right,
//   rear_left, rear_right. Config channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data) writes joystick_x (0), joystick_y (1), update_division (2);
//   it is always ready and should only be used while the block is idle.
//   One request at a time. Each request runs four 16-step shift-add
//   multiplier lanes once for the corner gains (refresh only, after the
//   bin and ROM read states S_IDX, S_RDX and S_RDY) and once for the
//   sample products. A new request is taken in the cycle after
//   the result is registered, even if the receiver has not taken it yet.
//   If the receiver stalls with a result still held, the next result waits
//   in the multiplier lanes and the input stays not ready.
//   Reset clears the gains to zero, the joystick offsets to zero and sets
//   update_division to 48; the first request after reset refreshes the gains.
// ----------------------------------------------------------------------------
module quad_pan_law_vca_top #(
	parameter int LAW_TABLE_DEPTH = qpan_pkg::LAW_TABLE_DEPTH,
	parameter int SAMPLE_BITS     = qpan_pkg::SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qpan_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [qpan_pkg::CFG_DATA_BITS-1:0]  cfg_data,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic signed [qpan_pkg::POS_BITS-1:0] cv_x,
	input  logic signed [qpan_pkg::POS_BITS-1:0] cv_y,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_BITS-1:0]       front_left,
	output logic signed [SAMPLE_BITS-1:0]       front_right,
	output logic signed [SAMPLE_BITS-1:0]       rear_left,
	output logic signed [SAMPLE_BITS-1:0]       rear_right
);

	localparam int GB = qpan_pkg::GAIN_BITS;
	localparam int PB = qpan_pkg::POS_BITS;
	localparam int IW = $clog2(LAW_TABLE_DEPTH);
	localparam int MW = (SAMPLE_BITS > GB + 1) ? SAMPLE_BITS : GB + 1;
	localparam int LANES = 4;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_IDX  = 3'd1;
	localparam logic [2:0] S_RDX  = 3'd2;
	localparam logic [2:0] S_RDY  = 3'd3;
	localparam logic [2:0] S_CGO  = 3'd4;
	localparam logic [2:0] S_CMUL = 3'd5;
	localparam logic [2:0] S_VGO  = 3'd6;
	localparam logic [2:0] S_VMUL = 3'd7;

	localparam logic [IW-1:0] IDX_LAST = IW'(LAW_TABLE_DEPTH - 1);

	logic [2:0] state_q;

	logic signed [PB-1:0] joy_x_q;
	logic signed [PB-1:0] joy_y_q;
	logic [PB-1:0]        div_q;
	logic [PB-1:0]        cnt_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [PB-1:0]          cvx_q;
	logic signed [PB-1:0]          cvy_q;

	logic [IW-1:0] ix_q;
	logic [IW-1:0] iy_q;
	logic [GB-1:0] gr_q;
	logic [GB-1:0] gl_q;
	logic [GB-1:0] corner_q [LANES];

	logic [IW-1:0] rom_addr_a;
	logic [IW-1:0] rom_addr_b;
	logic [GB-1:0] rom_a;
	logic [GB-1:0] rom_b;

	logic                  lane_start;
	logic signed [MW-1:0]  lane_mcand [LANES];
	logic [GB-1:0]         lane_mult [LANES];
	logic [LANES-1:0]      lane_busy;
	logic signed [MW:0]    lane_prod [LANES];
	logic signed [SAMPLE_BITS-1:0] lane_sat [LANES];

	logic          in_acc;
	logic          out_free;
	logic [PB-1:0] div_eff;
	logic [PB-1:0] cnt_inc;
	logic [IW-1:0] ix_d;
	logic [IW-1:0] iy_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;

	// position = joystick + 2*cv, clamped to Q1.15, then binned into the table
	function automatic logic [IW-1:0] axis_index(input logic signed [PB-1:0] joy,
			input logic signed [PB-1:0] cv);
		logic signed [PB+1:0] pos;
		logic [PB-1:0]        posc;
		logic [PB-1:0]        t16;
		logic [PB+IW:0]       prod;
		pos = {{2{joy[PB-1]}}, joy} + {cv[PB-1], cv, 1'b0};
		if (pos > (PB+2)'(signed'(2**(PB-1) - 1)))
			posc = {1'b0, {(PB-1){1'b1}}};
		else if (pos < -(PB+2)'(signed'(2**(PB-1))))
			posc = {1'b1, {(PB-1){1'b0}}};
		else
			posc = pos[PB-1:0];
		t16 = {~posc[PB-1], posc[PB-2:0]};
		prod = (PB+IW+1)'(t16) * (PB+IW+1)'(LAW_TABLE_DEPTH);
		return prod[PB +: IW];
	endfunction

	assign ix_d = axis_index(joy_x_q, cvx_q);
	assign iy_d = axis_index(joy_y_q, cvy_q);

	assign div_eff = (div_q == '0) ? PB'(1) : div_q;
	assign cnt_inc = cnt_q + 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_x_q <= '0;
			joy_y_q <= '0;
			div_q   <= qpan_pkg::UPDATE_DIVISION_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qpan_pkg::REG_JOYSTICK_X:      joy_x_q <= cfg_data;
				qpan_pkg::REG_JOYSTICK_Y:      joy_y_q <= cfg_data;
				qpan_pkg::REG_UPDATE_DIVISION: div_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q   <= (cnt_inc >= div_eff) ? '0 : cnt_inc;
						state_q <= (cnt_q == '0) ? S_IDX : S_VGO;
					end
				end
				S_IDX:  state_q <= S_RDX;
				S_RDX:  state_q <= S_RDY;
				S_RDY:  state_q <= S_CGO;
				S_CGO:  state_q <= S_CMUL;
				S_CMUL: begin
					if (!lane_busy[0])
						state_q <= S_VGO;
				end
				S_VGO:  state_q <= S_VMUL;
				S_VMUL: begin
					if (!lane_busy[0] && out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANES; k++)
				corner_q[k] <= '0;
		end else if (state_q == S_CMUL && !lane_busy[0]) begin
			for (int k = 0; k < LANES; k++)
				corner_q[k] <= lane_prod[k][GB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
			cvx_q    <= cv_x;
			cvy_q    <= cv_y;
		end
		if (state_q == S_IDX) begin
			ix_q <= ix_d;
			iy_q <= iy_d;
		end
		if (state_q == S_RDY) begin
			gr_q <= rom_a;
			gl_q <= rom_b;
		end
	end

	// right/front bin and its mirror for left/surround
	assign rom_addr_a = (state_q == S_RDX) ? ix_q : iy_q;
	assign rom_addr_b = IDX_LAST - rom_addr_a;

	qpan_law_rom #(
		.DEPTH (LAW_TABLE_DEPTH),
		.IW    (IW)
	) u_rom (
		.clk     (clk),
		.addr_a  (rom_addr_a),
		.addr_b  (rom_addr_b),
		.rdata_a (rom_a),
		.rdata_b (rom_b)
	);

	// lanes: FL, FR, SL, SR. Refresh: side gain x side gain; else sample x corner.
	assign lane_start = (state_q == S_CGO) || (state_q == S_VGO);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (state_q == S_CGO) begin
				lane_mcand[k] = MW'(signed'({1'b0, ((k % 2) == 0) ? gl_q : gr_q}));
				lane_mult[k]  = (k < 2) ? rom_a : rom_b;
			end else begin
				lane_mcand[k] = MW'(sample_q);
				lane_mult[k]  = corner_q[k];
			end
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		qpan_mul #(
			.MW (MW)
		) u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.mcand  (lane_mcand[g]),
			.mult   (lane_mult[g]),
			.busy   (lane_busy[g]),
			.prod   (lane_prod[g])
		);

		always_comb begin
			if (lane_prod[g] > (MW+1)'((longint'(1) <<< (SAMPLE_BITS-1)) - 1))
				lane_sat[g] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			else if (lane_prod[g] < -(MW+1)'(longint'(1) <<< (SAMPLE_BITS-1)))
				lane_sat[g] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			else
				lane_sat[g] = lane_prod[g][SAMPLE_BITS-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_VMUL && !lane_busy[0] && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_VMUL && !lane_busy[0] && out_free) begin
			front_left  <= lane_sat[0];
			front_right <= lane_sat[1];
			rear_left   <= lane_sat[2];
			rear_right  <= lane_sat[3];
		end
	end

endmodule

// File: sv/qpan_checker.sv
// ----------------------------------------------------------------------------
// qpan_checker
// Port-level checks for the quad panner, bound to the top level.
// ----------------------------------------------------------------------------
module qpan_checker #(
	parameter int SAMPLE_BITS = qpan_pkg::SAMPLE_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] front_left,
	input logic signed [SAMPLE_BITS-1:0] front_right,
	input logic signed [SAMPLE_BITS-1:0] rear_left,
	input logic signed [SAMPLE_BITS-1:0] rear_right
);

	// a held result must not move
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(front_left) &&
		$stable(front_right) && $stable(rear_left) && $stable(rear_right))
		else $error("result changed while stalled");

	// one request in flight: busy right after acceptance
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// a freshly registered result frees the input side
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("input not ready after result registered");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind quad_pan_law_vca_top qpan_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_qpan_checker (.*);
